// ===== rtl/core/mvpm_pkg.sv =====
`timescale 1ns / 1ps

package mvpm_pkg;

	localparam int VOICES      = 8;
	localparam int STORE_WORDS = 65536;
	localparam int STORE_AW    = $clog2(STORE_WORDS);
	localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;

	localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VOICES - 1);

	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUEUE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [15:0]        address;
		logic signed [15:0] sample_value;
		logic [16:0]        sound_length;
	} in_payload_t;

	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               queue_accepted;
	} out_payload_t;

	// Program counter of the sequencer.
	typedef enum logic [2:0] {
		ST_FETCH,
		ST_QSCAN,
		ST_TLOOP,
		ST_TLAST,
		ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_DISPATCH,
		COND_SCAN_DONE,
		COND_LAST,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic  fetch;
		logic  scan;
		logic  issue;
		logic  accum;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Microcode ROM: one control word per step. A step whose condition is false repeats.
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{fetch: 1'b0, scan: 1'b0, issue: 1'b0, accum: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, target: ST_FETCH};
		unique case (s)
			ST_FETCH: begin
				w.fetch = 1'b1;
				w.cond  = COND_DISPATCH;
			end
			ST_QSCAN: begin
				w.scan   = 1'b1;
				w.cond   = COND_SCAN_DONE;
				w.target = ST_EMIT;
			end
			ST_TLOOP: begin
				w.issue  = 1'b1;
				w.accum  = 1'b1;
				w.cond   = COND_LAST;
				w.target = ST_TLAST;
			end
			ST_TLAST: begin
				w.accum  = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_OUT_FREE;
				w.target = ST_FETCH;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = ST_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/mvpm_in_if.sv =====
`timescale 1ns / 1ps

interface mvpm_in_if
	import mvpm_pkg::*;
();
	logic        valid;
	logic        ready;
	in_payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mvpm_out_if.sv =====
`timescale 1ns / 1ps

interface mvpm_out_if
	import mvpm_pkg::*;
();
	logic         valid;
	logic         ready;
	out_payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/multi_voice_pcm_mixer.sv =====
`timescale 1ns / 1ps

// Multi-voice saturating PCM mixer: a 64K-word sample store and VOICES voice slots, run
// by a small microcoded sequencer. Every input beat, of any opcode, gives exactly one
// result beat. A queue's free-slot search looks at one slot per cycle; a tick's voice
// walk issues one store read per slot through the single read port and adds the
// registered word in the next cycle, with clipping after each add. The result goes to
// an output register, so the next beat is taken while a result waits; the sequencer
// holds in its emit step only if that register is still full. The store is not cleared
// by reset.
module multi_voice_pcm_mixer
	import mvpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mvpm_in_if.sink   req,
	mvpm_out_if.source rsp
);

	step_t              step_q, step_d;
	ctrl_t              ctrl;
	in_payload_t        item_q;
	logic [VIDX_W-1:0]  vidx_q;
	logic signed [15:0] acc_q;
	logic               accepted_q;
	logic               pend_q;
	logic [15:0]        rd_q;

	logic [VOICES-1:0]  active_q;
	logic [15:0]        start_q [VOICES];
	logic [16:0]        len_q   [VOICES];
	logic [16:0]        pos_q   [VOICES];

	logic [15:0]        store [STORE_WORDS];

	logic               out_valid_q;
	out_payload_t       out_q;

	logic               cur_active;
	logic [16:0]        cur_pos;
	logic [16:0]        cur_len;
	logic               play;
	logic               scan_hit;
	logic               last;
	logic               out_free;
	logic               take;
	logic [17:0]        rd_sum;
	logic [STORE_AW-1:0] rd_addr;
	logic signed [16:0] mix_sum;
	logic signed [15:0] mix_clip;

	assign ctrl       = ucode(step_q);
	assign cur_active = active_q[vidx_q];
	assign cur_pos    = pos_q[vidx_q];
	assign cur_len    = len_q[vidx_q];
	assign play       = cur_active && (cur_pos < cur_len);
	assign scan_hit   = (item_q.sound_length != 17'd0) && !cur_active;
	assign last       = (vidx_q == VIDX_LAST);
	assign out_free   = !out_valid_q || rsp.ready;
	assign take       = ctrl.fetch && req.valid;
	assign rd_sum     = 18'(start_q[vidx_q]) + 18'(cur_pos);
	assign rd_addr    = STORE_AW'(rd_sum);

	assign mix_sum = 17'(acc_q) + 17'(signed'(rd_q));
	always_comb begin
		if (mix_sum[16] != mix_sum[15]) begin
			mix_clip = mix_sum[16] ? PCM_MIN : PCM_MAX;
		end else begin
			mix_clip = mix_sum[15:0];
		end
	end

	assign req.ready   = ctrl.fetch;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		step_d = step_q;
		unique case (ctrl.cond)
			COND_ALWAYS:    step_d = ctrl.target;
			COND_DISPATCH: begin
				if (req.valid) begin
					unique case (req.payload.opcode)
						OP_QUEUE: step_d = ST_QSCAN;
						OP_TICK:  step_d = ST_TLOOP;
						default:  step_d = ST_EMIT;
					endcase
				end
			end
			COND_SCAN_DONE: if (scan_hit || last || item_q.sound_length == 17'd0) begin
				step_d = ctrl.target;
			end
			COND_LAST:      if (last) step_d = ctrl.target;
			COND_OUT_FREE:  if (out_free) step_d = ctrl.target;
			default:        step_d = ST_FETCH;
		endcase
	end

	// Sequencer datapath control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q     <= '0;
			acc_q      <= '0;
			accepted_q <= 1'b0;
			pend_q     <= 1'b0;
			active_q   <= '0;
		end else begin
			pend_q <= ctrl.issue && play;
			if (take) begin
				vidx_q     <= '0;
				acc_q      <= '0;
				accepted_q <= 1'b0;
			end
			if (ctrl.scan) begin
				if (scan_hit) begin
					active_q[vidx_q] <= 1'b1;
					accepted_q       <= 1'b1;
				end else if (!last) begin
					vidx_q <= vidx_q + 1'b1;
				end
			end
			if (ctrl.issue) begin
				if (cur_active && !play) begin
					active_q[vidx_q] <= 1'b0;
				end
				if (!last) begin
					vidx_q <= vidx_q + 1'b1;
				end
			end
			if (ctrl.accum && pend_q) begin
				acc_q <= mix_clip;
			end
		end
	end

	// Voice payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.scan && scan_hit) begin
			start_q[vidx_q] <= item_q.address;
			len_q[vidx_q]   <= item_q.sound_length;
			pos_q[vidx_q]   <= '0;
		end
		if (ctrl.issue && play) begin
			pos_q[vidx_q] <= cur_pos + 17'd1;
		end
		if (take) begin
			item_q <= req.payload;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.payload.opcode == OP_LOAD) begin
			store[STORE_AW'(req.payload.address)] <= req.payload.sample_value;
		end
		if (ctrl.issue) begin
			rd_q <= store[rd_addr];
		end
	end

	// Output register: fill from emit, drop on a taken beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			out_q.mixed_sample   <= acc_q;
			out_q.queue_accepted <= accepted_q;
		end
	end

endmodule

// ===== rtl/core/mvpm_checker.sv =====
`timescale 1ns / 1ps

module mvpm_checker
	import mvpm_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_ready,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input out_payload_t rsp_payload
);

	logic [1:0] outstanding_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	// Count beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_beat && !rsp_beat) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (rsp_beat && !req_beat) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 2'd0)
		else $error("result with no beat outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q != 2'd3)
		else $error("more than two beats in flight");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.queue_accepted |-> rsp_payload.mixed_sample == 16'sd0)
		else $error("queue result carries a sample");

endmodule

bind multi_voice_pcm_mixer mvpm_checker u_mvpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

// ===== tb/pcm_mix_checker.sv =====
`timescale 1ns / 1ps

module pcm_mix_checker
	import mvpm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  in_payload_t  in_beat,
	input  logic         out_valid,
	input  logic         out_ready,
	input  out_payload_t out_beat,
	output int           fail_count,
	output int           outstanding
);

	logic signed [15:0] pcm_store [STORE_WORDS];
	logic               slot_busy [VOICES];
	logic        [15:0] slot_base [VOICES];
	logic        [16:0] slot_len  [VOICES];
	logic        [16:0] slot_pos  [VOICES];

	out_payload_t pending_results [$];
	int           beats_seen;

	// Apply one input beat to the shadow state and return the result it causes.
	function automatic out_payload_t mix_predict(in_payload_t beat);
		out_payload_t res;
		int           acc;
		logic [15:0]  at;
		res = '0;
		acc = 0;
		case (beat.opcode)
			OP_LOAD: begin
				pcm_store[beat.address] = beat.sample_value;
			end
			OP_QUEUE: begin
				for (int v = 0; v < VOICES; v++) begin
					if (beat.sound_length != 0 && !res.queue_accepted && !slot_busy[v]) begin
						slot_busy[v]       = 1'b1;
						slot_base[v]       = beat.address;
						slot_len[v]        = beat.sound_length;
						slot_pos[v]        = '0;
						res.queue_accepted = 1'b1;
					end
				end
			end
			OP_TICK: begin
				for (int v = 0; v < VOICES; v++) begin
					if (slot_busy[v]) begin
						if (slot_pos[v] >= slot_len[v]) begin
							slot_busy[v] = 1'b0;
						end else begin
							// sound address wraps with the store
							at  = slot_base[v] + slot_pos[v][15:0];
							acc = acc + pcm_store[at];
							if (acc > PCM_MAX)
								acc = PCM_MAX;
							else if (acc < PCM_MIN)
								acc = PCM_MIN;
							slot_pos[v] = slot_pos[v] + 17'd1;
						end
					end
				end
			end
			default: ;
		endcase
		res.mixed_sample = acc[15:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_payload_t want;
		if (!arst_n) begin
			for (int a = 0; a < STORE_WORDS; a++)
				pcm_store[a] = '0;
			for (int v = 0; v < VOICES; v++) begin
				slot_busy[v] = 1'b0;
				slot_base[v] = '0;
				slot_len[v]  = '0;
				slot_pos[v]  = '0;
			end
			pending_results.delete();
			fail_count  = 0;
			outstanding = 0;
			beats_seen  = 0;
		end else begin
			// results always trail their beat, so retire before adding
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat %0d arrived with nothing pending",
							$realtime, beats_seen);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (want.mixed_sample !== out_beat.mixed_sample ||
							want.queue_accepted !== out_beat.queue_accepted) begin
						if (fail_count < 10)
							$display("%0t: result beat %0d: mixed_sample exp %0d got %0d",
								$realtime, beats_seen, want.mixed_sample,
								out_beat.mixed_sample,
								", queue_accepted exp %0b got %0b",
								want.queue_accepted, out_beat.queue_accepted);
						fail_count++;
					end
				end
				beats_seen++;
			end
			if (in_valid && in_ready)
				pending_results.push_back(mix_predict(in_beat));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/tb_multi_voice_pcm_mixer.sv =====
`timescale 1ns / 1ps

module tb_multi_voice_pcm_mixer;
	import mvpm_pkg::*;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam int         ITEM_COUNT = 1750;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mvpm_in_if  req ();
	mvpm_out_if rsp ();

	int fail_count;
	int outstanding;

	// Stimulus-side view of the voices, kept so no tick reads an unwritten word.
	bit          loaded [STORE_WORDS];
	bit          v_busy [VOICES];
	int          v_base [VOICES];
	int          v_len  [VOICES];
	int          v_pos  [VOICES];
	logic [15:0] recent_start [16];
	int          sent;
	bit          calm;

	multi_voice_pcm_mixer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	pcm_mix_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_beat     (req.payload),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_beat    (rsp.payload),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [15:0] pcm_value();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 255));
			3: return 16'(-int'($urandom_range(1, 256)));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
			input logic [15:0] val, input logic [16:0] len);
		in_payload_t beat;
		bit          placed;
		beat.opcode       = op;
		beat.address      = addr;
		beat.sample_value = val;
		beat.sound_length = len;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req.payload <= beat;
		req.valid   <= 1'b1;
		do @(posedge clk); while (!req.ready);
		placed = 1'b0;
		case (op)
			OP_LOAD: begin
				loaded[addr] = 1'b1;
			end
			OP_QUEUE: begin
				for (int v = 0; v < VOICES; v++) begin
					if (len != 0 && !placed && !v_busy[v]) begin
						v_busy[v] = 1'b1;
						v_base[v] = int'(addr);
						v_len[v]  = int'(len);
						v_pos[v]  = 0;
						placed    = 1'b1;
					end
				end
			end
			OP_TICK: begin
				for (int v = 0; v < VOICES; v++) begin
					if (v_busy[v]) begin
						if (v_pos[v] >= v_len[v])
							v_busy[v] = 1'b0;
						else
							v_pos[v]++;
					end
				end
			end
			default: ;
		endcase
		if (op != OP_SPARE)
			sent++;
	endtask

	// Load every word the next tick will read, then send the tick.
	task automatic tick_beat();
		logic [15:0] at;
		for (int v = 0; v < VOICES; v++) begin
			at = 16'(v_base[v] + v_pos[v]);
			if (v_busy[v] && v_pos[v] < v_len[v] && !loaded[at])
				send_item(OP_LOAD, at, pcm_value(), 17'($urandom_range(0, 65536)));
		end
		send_item(OP_TICK, 16'($urandom), 16'($urandom), 17'($urandom_range(0, 65536)));
	endtask

	// Hold the sender until every pending result is back.
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("tb_multi_voice_pcm_mixer failed");
		$finish;
	end

	initial begin
		int          pick;
		int          free_slots;
		int          hogs;
		int          phase_end;
		bit          mid_drain;
		logic [16:0] len;
		logic [15:0] start;
		req.valid   <= 1'b0;
		req.payload <= '0;
		sent      = 0;
		calm      = 1'b0;
		phase_end = 0;
		mid_drain = 1'b0;
		for (int i = 0; i < 16; i++)
			recent_start[i] = 16'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty mix, then the spare opcode
		tick_beat();
		send_item(OP_SPARE, 16'hFFFF, 16'hFFFF, 17'h10000);
		send_item(OP_LOAD, 16'h0000, 16'h7FFF, 17'd0);
		send_item(OP_LOAD, 16'hFFFF, 16'h8000, 17'h1FFFF & 17'd65536);
		// sound that wraps from the top of the store to address zero
		send_item(OP_QUEUE, 16'hFFFF, 16'h0000, 17'd2);
		send_item(OP_QUEUE, 16'h1234, 16'h7FFF, 17'd0);
		repeat (3) tick_beat();
		// fill every slot, overflow one, clip high
		repeat (VOICES) send_item(OP_QUEUE, 16'h0000, 16'h0000, 17'd1);
		send_item(OP_QUEUE, 16'h0000, 16'h0000, 17'd65536);
		repeat (2) tick_beat();
		// clip low
		send_item(OP_LOAD, 16'h0002, 16'h8000, 17'd0);
		repeat (2) send_item(OP_QUEUE, 16'h0002, 16'hFFFF, 17'd1);
		tick_beat();
		drain();

		while (sent < ITEM_COUNT) begin
			if (sent >= phase_end) begin
				calm      = (sent >= ITEM_COUNT - 300) || ($urandom_range(0, 3) == 0);
				phase_end = sent + 150;
			end
			if (!mid_drain && sent >= ITEM_COUNT / 2) begin
				drain();
				mid_drain = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(OP_LOAD, 16'($urandom), pcm_value(), 17'($urandom_range(0, 65536)));
			end else if (pick < 10) begin
				send_item(OP_SPARE, 16'($urandom), 16'($urandom),
					17'($urandom_range(0, 65536)));
			end else if (pick < 32) begin
				free_slots = 0;
				hogs       = 0;
				for (int v = 0; v < VOICES; v++) begin
					if (!v_busy[v])
						free_slots++;
					else if (v_len[v] >= 256)
						hogs++;
				end
				// long sounds hold a slot for good, so allow only a couple
				if (free_slots == 0)
					len = 17'($urandom_range(0, 65536));
				else if (hogs < 2 && $urandom_range(0, 49) == 0)
					len = 17'($urandom_range(256, 65536));
				else if ($urandom_range(0, 19) == 0)
					len = 17'd0;
				else
					len = 17'($urandom_range(1, 48));
				case ($urandom_range(0, 4))
					0, 1: start = recent_start[$urandom_range(0, 15)];
					2: start = 16'hFFFF - 16'($urandom_range(0, 30));
					default: start = 16'($urandom);
				endcase
				recent_start[$urandom_range(0, 15)] = start;
				send_item(OP_QUEUE, start, 16'($urandom), len);
			end else begin
				tick_beat();
			end
		end

		drain();
		repeat (24) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_multi_voice_pcm_mixer passed");
		else
			$display("tb_multi_voice_pcm_mixer failed");
		$finish;
	end

endmodule
